/* design/kpcc_pkg.sv */
// Shared types, codes and constants for the keypad press and chord classifier.
package kpcc_pkg;

  // Default sizes of the pad, the rule table and the hold timers
  localparam int KPCC_NUM_KEYS   = 16;
  localparam int KPCC_MAX_RULES  = 8;
  localparam int KPCC_TIMER_BITS = 16;

  // Fixed field widths
  localparam int KEY_W    = 16;  // key bitmaps on the ports
  localparam int THR_W    = 16;  // long-press threshold
  localparam int CNT_W    = 4;   // rule count
  localparam int PAIRS_W  = 64;  // rule pair table
  localparam int KIDX_W   = 4;   // key number in a rule or pairing key
  localparam int COMBO_W  = 4;   // combo id
  localparam int CLR_W    = 3;   // clear mask
  localparam int CMP_W    = 17;  // timer plus bonus against threshold, no wrap
  localparam int CFG_W    = 64;  // config write data
  localparam int CFG_IDX_W = 2;

  // Stream widths
  localparam int IN_USER_W  = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  // Input tdata bit positions
  localparam int IN_MASK_LO = 0;
  localparam int IN_PAIR_BIT = 16;
  localparam int IN_CLR_LO  = 17;

  // Clear mask bits
  localparam int CLR_SHORT = 0;
  localparam int CLR_LONG  = 1;
  localparam int CLR_COMBO = 2;

  typedef enum logic [1:0] {
    OP_KEY_EVENT  = 2'd0,
    OP_HOLD_TICK  = 2'd1,
    OP_COMBO_TICK = 2'd2,
    OP_CLEAR      = 2'd3
  } kpcc_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_THRESHOLD = 2'd0,
    CFG_RULE_COUNT     = 2'd1,
    CFG_RULE_PAIRS     = 2'd2,
    CFG_PAIRING_KEY    = 2'd3
  } kpcc_cfg_e;

  // Shared controls for every key lane
  typedef struct packed {
    logic              en;
    kpcc_op_e          op;
    logic              pairing_mode;
    logic [KIDX_W-1:0] pairing_key;
    logic [THR_W-1:0]  thr;
  } kpcc_key_ctl_t;

  // What one key lane reports for the current beat
  typedef struct packed {
    logic tone;
    logic set_short;
    logic set_long;
  } kpcc_key_res_t;

  // Shared controls for every rule lane
  typedef struct packed {
    logic              en;      // combo evaluation allowed this beat
    logic              bonus;   // one extra tick, for the release check
    logic [CNT_W-1:0]  rule_count;
    logic [THR_W-1:0]  thr;
  } kpcc_rule_ctl_t;

  // Result beat, packed into output tdata with the last field at bit 0
  typedef struct packed {
    logic [2:0]         pad;
    logic               fired;
    logic [KEY_W-1:0]   tone;
    logic [COMBO_W-1:0] combo;
    logic [KEY_W-1:0]   long_pend;
    logic [KEY_W-1:0]   short_pend;
  } kpcc_result_t;

endpackage

/* design/keypad_press_combo_classifier.sv */
// Top level of the keypad press and chord classifier: lanes, merge, latches and output.
//
// Classifies a pad of NUM_KEYS keys, one item per clock unless held off: every key has
// its own lane (hold timer, long lock, edge test) and every combo rule its own lane
// (pair decode, hold and readiness check, partner search); a merge stage picks the
// lowest matching rule and updates the pending latches. The whole update is done in
// the cycle that takes the input beat; its result beat is loaded at that edge into the
// output register if free or draining, and offered from the next cycle on, else into
// the skid entry behind it, which absorbs one beat while the consumer stalls. Input is
// held off only while both entries are full. With a ready consumer the throughput is
// one item per cycle. The operation code travels in s_axis_tuser; configuration is
// written through a plain write port only while the block is idle; the user ensures it.
module keypad_press_combo_classifier #(
  parameter int NUM_KEYS   = kpcc_pkg::KPCC_NUM_KEYS,
  parameter int MAX_RULES  = kpcc_pkg::KPCC_MAX_RULES,
  parameter int TIMER_BITS = kpcc_pkg::KPCC_TIMER_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write port
  input  logic                            cfg_we_i,
  input  logic [kpcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kpcc_pkg::CFG_W-1:0]      cfg_wdata_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [kpcc_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // key bitmap, pairing_mode,
                                                         // clear_mask, pad
  input  logic [kpcc_pkg::IN_USER_W-1:0]  s_axis_tuser,  // operation
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [kpcc_pkg::OUT_DATA_W-1:0] m_axis_tdata   // short, long, combo, tone,
                                                         // fired, pad
);
  import kpcc_pkg::*;

  // Config registers
  logic [THR_W-1:0]   thr_q;
  logic [CNT_W-1:0]   rule_cnt_q;
  logic [PAIRS_W-1:0] pairs_q;
  logic [KIDX_W-1:0]  pkey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= THR_W'(100);
      rule_cnt_q <= CNT_W'(7);
      pairs_q    <= '0;
      pkey_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (kpcc_cfg_e'(cfg_idx_i))
        CFG_LONG_THRESHOLD: thr_q      <= cfg_wdata_i[THR_W-1:0];
        CFG_RULE_COUNT:     rule_cnt_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_RULE_PAIRS:     pairs_q    <= cfg_wdata_i[PAIRS_W-1:0];
        CFG_PAIRING_KEY:    pkey_q     <= cfg_wdata_i[KIDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input beat decode
  logic                  push;
  kpcc_op_e              op;
  logic [NUM_KEYS-1:0]   next_keys;
  logic                  pairing;
  logic [CLR_W-1:0]      clr;

  assign push      = s_axis_tvalid && s_axis_tready;
  assign op        = kpcc_op_e'(s_axis_tuser);
  assign next_keys = s_axis_tdata[IN_MASK_LO +: NUM_KEYS];
  assign pairing   = s_axis_tdata[IN_PAIR_BIT];
  assign clr       = s_axis_tdata[IN_CLR_LO +: CLR_W];

  // Block state
  logic [NUM_KEYS-1:0] down_q, down_d;
  logic [NUM_KEYS-1:0] short_q, short_d;
  logic [NUM_KEYS-1:0] long_q, long_d;
  logic [COMBO_W-1:0]  combo_q, combo_d;
  logic                clock_q, clock_d;  // combo lock

  // Rule lanes
  kpcc_rule_ctl_t                        rule_ctl;
  logic [NUM_KEYS-1:0][TIMER_BITS-1:0]   timers;
  logic [MAX_RULES-1:0]                  match;
  logic [MAX_RULES-1:0][NUM_KEYS-1:0]    rmask, rpartner;

  assign rule_ctl.en = ((op == OP_KEY_EVENT) || (op == OP_COMBO_TICK)) && !clock_q;
  assign rule_ctl.bonus      = (op == OP_KEY_EVENT);
  assign rule_ctl.rule_count = rule_cnt_q;
  assign rule_ctl.thr        = thr_q;

  for (genvar r = 0; r < MAX_RULES; r++) begin : g_rule
    kpcc_rule_lane #(
      .RULE_IDX  (r),
      .NUM_KEYS  (NUM_KEYS),
      .TIMER_BITS(TIMER_BITS)
    ) u_rule (
      .ctl_i    (rule_ctl),
      .pair_i   (pairs_q[8*r +: 8]),
      .down_i   (down_q),
      .timers_i (timers),
      .match_o  (match[r]),
      .mask_o   (rmask[r]),
      .partner_o(rpartner[r])
    );
  end

  // Merge: lowest matching rule wins, partners are ORed over rules unless the combo lock is set
  logic                fire;
  logic [COMBO_W-1:0]  fire_id;
  logic [NUM_KEYS-1:0] fire_mask, partner_any;

  always_comb begin
    fire_id     = '0;
    fire_mask   = '0;
    partner_any = '0;
    for (int r = MAX_RULES - 1; r >= 0; r--) begin
      if (match[r]) begin
        fire_id   = COMBO_W'(r + 1);
        fire_mask = rmask[r];
      end
      partner_any = partner_any | rpartner[r];
    end
    fire = |match;
    if (clock_q) partner_any = '0;
  end

  // Key lanes
  kpcc_key_ctl_t                 key_ctl;
  kpcc_key_res_t [NUM_KEYS-1:0]  kres;
  logic [NUM_KEYS-1:0]           set_short, set_long, tone;

  assign key_ctl.en           = push;
  assign key_ctl.op           = op;
  assign key_ctl.pairing_mode = pairing;
  assign key_ctl.pairing_key  = pkey_q;
  assign key_ctl.thr          = thr_q;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    kpcc_key_lane #(
      .KEY_IDX   (k),
      .TIMER_BITS(TIMER_BITS)
    ) u_key (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (key_ctl),
      .now_i      (next_keys[k]),
      .down_i     (down_q[k]),
      .combo_hit_i(fire_mask[k]),
      .partner_i  (partner_any[k]),
      .timer_o    (timers[k]),
      .res_o      (kres[k])
    );
    assign set_short[k] = kres[k].set_short;
    assign set_long[k]  = kres[k].set_long;
    assign tone[k]      = kres[k].tone;
  end

  // Latch and lock update
  always_comb begin
    down_d  = down_q;
    short_d = short_q;
    long_d  = long_q;
    combo_d = combo_q;
    clock_d = clock_q;
    if (fire) begin
      combo_d = fire_id;
      clock_d = 1'b1;
      short_d = short_d & ~fire_mask;
      long_d  = long_d & ~fire_mask;
    end
    unique case (op)
      OP_KEY_EVENT: begin
        short_d = short_d | set_short;
        down_d  = next_keys;
      end
      OP_HOLD_TICK: begin
        long_d = long_d | set_long;
      end
      OP_COMBO_TICK: begin
        if (!fire && (down_q == '0)) clock_d = 1'b0;
      end
      OP_CLEAR: begin
        if (clr[CLR_SHORT]) short_d = '0;
        if (clr[CLR_LONG])  long_d  = '0;
        if (clr[CLR_COMBO]) combo_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q  <= '0;
      short_q <= '0;
      long_q  <= '0;
      combo_q <= '0;
      clock_q <= 1'b0;
    end else if (push) begin
      down_q  <= down_d;
      short_q <= short_d;
      long_q  <= long_d;
      combo_q <= combo_d;
      clock_q <= clock_d;
    end
  end

  // Result beat
  kpcc_result_t res;

  always_comb begin
    res            = '0;
    res.short_pend = KEY_W'(short_d);
    res.long_pend  = KEY_W'(long_d);
    res.combo      = combo_d;
    res.tone       = KEY_W'(tone);
    res.fired      = fire;
  end

  // Output register plus skid entry
  logic                  out_vld_q, skid_vld_q, pop;
  logic [OUT_DATA_W-1:0] out_dat_q, skid_dat_q;

  assign pop = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || pop) begin
      out_vld_q  <= skid_vld_q || push;
      skid_vld_q <= skid_vld_q && push;
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_dat_q <= skid_dat_q;
        if (push) skid_dat_q <= res;
      end else if (push) begin
        out_dat_q <= res;
      end
    end else if (push) begin
      skid_dat_q <= res;
    end
  end

  assign s_axis_tready = !skid_vld_q;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_dat_q;

endmodule

/* design/kpcc_key_lane.sv */
// One key lane: hold timer, long-press lock and press/release classification.
module kpcc_key_lane #(
  parameter int KEY_IDX    = 0,
  parameter int TIMER_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kpcc_pkg::kpcc_key_ctl_t ctl_i,
  input  logic                   now_i,        // key in the new bitmap
  input  logic                   down_i,       // key currently held
  input  logic                   combo_hit_i,  // key belongs to the rule firing now
  input  logic                   partner_i,    // a combo partner is held
  output logic [TIMER_BITS-1:0]  timer_o,
  output kpcc_pkg::kpcc_key_res_t res_o
);
  import kpcc_pkg::*;

  logic [TIMER_BITS-1:0] timer_q, timer_d, timer_inc;
  logic                  lock_q, lock_d;
  logic                  press, release_e, hold, long_hit, tone_ok;

  // Edge and tick decode
  always_comb begin
    press     = (ctl_i.op == OP_KEY_EVENT) && now_i && !down_i;
    release_e = (ctl_i.op == OP_KEY_EVENT) && !now_i && down_i;
    hold      = (ctl_i.op == OP_HOLD_TICK) && down_i;
    timer_inc = (timer_q != {TIMER_BITS{1'b1}}) ? timer_q + 1'b1 : timer_q;
    long_hit  = hold && (CMP_W'(timer_inc) >= CMP_W'(ctl_i.thr)) && !lock_q && !partner_i;
    tone_ok   = !(ctl_i.pairing_mode && (ctl_i.pairing_key == KIDX_W'(KEY_IDX)));
  end

  // Report for this beat
  always_comb begin
    res_o.tone      = (press || long_hit) && tone_ok;
    res_o.set_short = release_e && (CMP_W'(timer_q) < CMP_W'(ctl_i.thr));
    res_o.set_long  = long_hit;
  end

  // Next timer and lock
  always_comb begin
    timer_d = timer_q;
    lock_d  = lock_q;
    unique case (ctl_i.op)
      OP_KEY_EVENT: begin
        if (press || release_e) begin
          timer_d = '0;
          lock_d  = 1'b0;
        end else if (combo_hit_i) begin
          lock_d = 1'b1;
        end
      end
      OP_HOLD_TICK: begin
        if (hold) timer_d = timer_inc;
        if (long_hit) lock_d = 1'b1;
      end
      OP_COMBO_TICK: begin
        if (combo_hit_i) lock_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
      lock_q  <= 1'b0;
    end else if (ctl_i.en) begin
      timer_q <= timer_d;
      lock_q  <= lock_d;
    end
  end

  assign timer_o = timer_q;

endmodule

/* design/kpcc_rule_lane.sv */
// One combo rule lane: decodes its key pair, checks hold and readiness, finds partners.
module kpcc_rule_lane #(
  parameter int RULE_IDX   = 0,
  parameter int NUM_KEYS   = 16,
  parameter int TIMER_BITS = 16
) (
  input  kpcc_pkg::kpcc_rule_ctl_t                 ctl_i,
  input  logic [7:0]                               pair_i,
  input  logic [NUM_KEYS-1:0]                      down_i,
  input  logic [NUM_KEYS-1:0][TIMER_BITS-1:0]      timers_i,
  output logic                                     match_o,
  output logic [NUM_KEYS-1:0]                      mask_o,
  output logic [NUM_KEYS-1:0]                      partner_o
);
  import kpcc_pkg::*;

  localparam int KeyW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [KIDX_W-1:0]     first, second;
  logic                  valid, active, held, ready_a, ready_b;
  logic [TIMER_BITS-1:0] t_a, t_b;

  assign first  = pair_i[KIDX_W-1:0];
  assign second = pair_i[2*KIDX_W-1:KIDX_W];
  assign valid  = ({1'b0, first} < (KIDX_W+1)'(NUM_KEYS)) &&
                  ({1'b0, second} < (KIDX_W+1)'(NUM_KEYS));
  assign active = ctl_i.rule_count > CNT_W'(RULE_IDX);

  // Key mask of the pair and partner hits
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      mask_o[k]    = valid && ((first == KIDX_W'(k)) || (second == KIDX_W'(k)));
      partner_o[k] = valid && active &&
                     (((first == KIDX_W'(k)) && down_i[second[KeyW-1:0]]) ||
                      ((second == KIDX_W'(k)) && down_i[first[KeyW-1:0]]));
    end
  end

  // Timer readiness of both keys
  always_comb begin
    t_a     = timers_i[first[KeyW-1:0]];
    t_b     = timers_i[second[KeyW-1:0]];
    ready_a = (CMP_W'(t_a) + CMP_W'(ctl_i.bonus)) >= CMP_W'(ctl_i.thr);
    ready_b = (CMP_W'(t_b) + CMP_W'(ctl_i.bonus)) >= CMP_W'(ctl_i.thr);
    held    = (down_i & mask_o) == mask_o;
  end

  assign match_o = ctl_i.en && valid && active && held && ready_a && ready_b;

endmodule

/* design/kpcc_checker.sv */
// Port-level checks of the classifier and their attachment to the top level.
module kpcc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [kpcc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import kpcc_pkg::*;

  // A stalled result beat stays valid
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // Input is only held off while a result is waiting
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  // A fired combo always leaves a pending combo id
  a_fired_has_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3*KEY_W + COMBO_W] |->
      (m_axis_tdata[2*KEY_W +: COMBO_W] != '0))
    else $error("combo fired without a pending combo id");

endmodule

bind keypad_press_combo_classifier kpcc_checker u_kpcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
